@@ hdl/edf_task_scheduler_macros.svh @@
// Assertion macros shared by the scheduler checker
`ifndef EDF_TASK_SCHEDULER_MACROS_SVH
`define EDF_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define ETS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define ETS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ets_pkg.sv @@
// Shared types and constants of the EDF task scheduler
package ets_pkg;

    // Function codes of an input word
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Field widths fixed by the interface
    localparam int SLOT_W   = 4;
    localparam int FIELD_W  = 16;
    localparam int COUNT_W  = 5;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // write the accepted load word into the table
        logic start;   // clear the scan pointer and the best candidate
        logic scan;    // issue the next table read
        logic commit;  // charge one unit to the winner and emit the result
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;  // all entries in use have been issued
        logic out_busy;   // result register full and not taken this cycle
    } sts_t;

endpackage

@@ hdl/ets_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module ets_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ets_ctrl.sv @@
// Scheduler controller: input handshake and scan/commit sequencing
module ets_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_func,
    output logic          s_ready,
    input  ets_pkg::sts_t sts,
    output ets_pkg::cmd_t cmd
);

    ets_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ets_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ets_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == ets_pkg::FUNC_TICK) begin
                        cmd.start  = 1'b1;
                        state_next = ets_pkg::ST_SCAN;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ets_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ets_pkg::ST_COMMIT;
                end
            end
            ets_pkg::ST_COMMIT: begin
                // wait for room in the result register
                if (!sts.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ets_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ets_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/ets_datapath.sv @@
// Scheduler datapath: task table, done marks, EDF compare and result register
module ets_datapath #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ets_pkg::cmd_t                   cmd,
    output ets_pkg::sts_t                   sts,
    input  logic                            cfg_we,
    input  logic [ets_pkg::COUNT_W-1:0]     cfg_wdata,
    input  logic [ets_pkg::SLOT_W-1:0]      s_task_slot,
    input  logic [ets_pkg::FIELD_W-1:0]     s_release_time,
    input  logic [ets_pkg::FIELD_W-1:0]     s_exec_time,
    input  logic [ets_pkg::FIELD_W-1:0]     s_abs_deadline,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ets_pkg::FIELD_W-1:0]     m_slot_time,
    output logic                            m_task_ran,
    output logic [ets_pkg::SLOT_W-1:0]      m_task_id,
    output logic                            m_task_finished,
    output logic                            m_all_done
);

    localparam int IDX_W  = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int TW     = TIME_BITS;
    localparam int REM_W  = ets_pkg::FIELD_W;
    localparam int WORD_W = 2 * TW + REM_W;

    // Configuration and scheduler state
    logic [ets_pkg::COUNT_W-1:0] task_count_reg;
    logic [MAX_TASKS-1:0]        done_reg, done_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [TW-1:0]               tick_reg;

    // Scan pointer and read pipeline
    logic [IDX_W:0]   idx_reg;
    logic [IDX_W:0]   limit;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    // Best candidate so far
    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [TW-1:0]    best_rel_reg;
    logic [REM_W-1:0] best_rem_reg;
    logic [TW-1:0]    best_dl_reg;

    // Result register
    logic                        m_valid_reg;
    logic [ets_pkg::FIELD_W-1:0] slot_time_reg;
    logic                        ran_reg;
    logic [ets_pkg::SLOT_W-1:0]  id_reg;
    logic                        fin_reg;
    logic                        all_done_reg;

    // Table RAM word: {release, remaining, deadline}
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [TW-1:0]     rd_rel;
    logic [REM_W-1:0]  rd_rem;
    logic [TW-1:0]     rd_dl;

    logic             load_ok;
    logic [IDX_W-1:0] slot_idx;
    logic             exec_zero;
    logic             cand;
    logic             take;
    logic [REM_W-1:0] rem_dec;
    logic             fin_now;

    assign slot_idx  = IDX_W'(s_task_slot);
    assign load_ok   = cmd.load && (32'(s_task_slot) < 32'(MAX_TASKS));
    assign exec_zero = (s_exec_time == '0);

    // Entries taking part: task_count clipped to the table size
    assign limit = (32'(task_count_reg) < 32'(MAX_TASKS)) ?
                   (IDX_W + 1)'(task_count_reg) : (IDX_W + 1)'(MAX_TASKS);

    assign sts.scan_done = (idx_reg >= limit);
    assign sts.out_busy  = m_valid_reg && !m_ready;

    assign rd_rel = ram_rdata[WORD_W-1 -: TW];
    assign rd_rem = ram_rdata[TW +: REM_W];
    assign rd_dl  = ram_rdata[TW-1:0];

    // Runnable test and earliest-deadline compare, lowest index keeps ties
    assign cand = !done_reg[rd_idx_reg] && (rd_rem != '0) && (rd_rel <= tick_reg);
    assign take = rd_vld_reg && cand && (!found_reg || (rd_dl < best_dl_reg));

    assign rem_dec = best_rem_reg - REM_W'(1);
    assign fin_now = found_reg && (rem_dec == '0);

    // Table writes: load word or winner write-back
    always_comb begin
        if (cmd.load) begin
            ram_we    = load_ok;
            ram_waddr = slot_idx;
            ram_wdata = {TW'(s_release_time), s_exec_time, TW'(s_abs_deadline)};
        end else begin
            ram_we    = cmd.commit && found_reg;
            ram_waddr = best_idx_reg;
            ram_wdata = {best_rel_reg, rem_dec, best_dl_reg};
        end
    end

    ets_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Done marks and completed count
    always_comb begin
        done_next  = done_reg;
        count_next = count_reg;
        if (load_ok) begin
            count_next = count_reg - CNT_W'(done_reg[slot_idx]) + CNT_W'(exec_zero);
            done_next[slot_idx] = exec_zero;
        end else if (cmd.commit && fin_now) begin
            count_next = count_reg + CNT_W'(1);
            done_next[best_idx_reg] = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_count_reg <= '0;
            done_reg       <= '0;
            count_reg      <= '0;
            tick_reg       <= '0;
            idx_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                task_count_reg <= cfg_wdata;
            end
            done_reg  <= done_next;
            count_reg <= count_next;
            if (cmd.commit) begin
                tick_reg <= tick_reg + TW'(1);
            end
            if (cmd.start) begin
                idx_reg <= '0;
            end else if (cmd.scan && !sts.scan_done) begin
                idx_reg <= idx_reg + (IDX_W + 1)'(1);
            end
            rd_vld_reg <= cmd.scan && !sts.scan_done;
            if (cmd.start) begin
                found_reg <= 1'b0;
            end else if (take) begin
                found_reg <= 1'b1;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Candidate and result payload
    always_ff @(posedge aclk) begin
        rd_idx_reg <= idx_reg[IDX_W-1:0];
        if (take) begin
            best_idx_reg <= rd_idx_reg;
            best_rel_reg <= rd_rel;
            best_rem_reg <= rd_rem;
            best_dl_reg  <= rd_dl;
        end
        if (cmd.commit) begin
            slot_time_reg <= ets_pkg::FIELD_W'(tick_reg);
            ran_reg       <= found_reg;
            id_reg        <= found_reg ? ets_pkg::SLOT_W'(best_idx_reg) : '0;
            fin_reg       <= fin_now;
            all_done_reg  <= (32'(count_next) == 32'(task_count_reg));
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_slot_time     = slot_time_reg;
    assign m_task_ran      = ran_reg;
    assign m_task_id       = id_reg;
    assign m_task_finished = fin_reg;
    assign m_all_done      = all_done_reg;

endmodule

@@ hdl/edf_task_scheduler.sv @@
// Tick: accepted in IDLE, then SCAN reads the min(task_count, MAX_TASKS) entries in use and
// COMMIT charges the winner and registers the result word. Commit stalls while
// the previous result word is still held; the scan reads one table entry per cycle.
// Load: written into the table at the accepting edge; back-to-back loads run 1 per cycle.
// Reset (sync, active low) clears task_count, done marks, counts, tick and handshake state.
module edf_task_scheduler #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [ets_pkg::COUNT_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [ets_pkg::SLOT_W-1:0]  s_task_slot,
    input  logic [ets_pkg::FIELD_W-1:0] s_release_time,
    input  logic [ets_pkg::FIELD_W-1:0] s_exec_time,
    input  logic [ets_pkg::FIELD_W-1:0] s_abs_deadline,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ets_pkg::FIELD_W-1:0] m_slot_time,
    output logic                        m_task_ran,
    output logic [ets_pkg::SLOT_W-1:0]  m_task_id,
    output logic                        m_task_finished,
    output logic                        m_all_done
);

    ets_pkg::cmd_t cmd;
    ets_pkg::sts_t sts;

    // Sequencer
    ets_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table, compare and result register
    ets_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_task_slot     (s_task_slot),
        .s_release_time  (s_release_time),
        .s_exec_time     (s_exec_time),
        .s_abs_deadline  (s_abs_deadline),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot_time     (m_slot_time),
        .m_task_ran      (m_task_ran),
        .m_task_id       (m_task_id),
        .m_task_finished (m_task_finished),
        .m_all_done      (m_all_done)
    );

endmodule

@@ hdl/ets_checker.sv @@
// Port-level checker for the EDF task scheduler, bound to the top level
`include "edf_task_scheduler_macros.svh"

module ets_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_func,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [ets_pkg::FIELD_W-1:0] m_slot_time,
    input logic                        m_task_ran,
    input logic [ets_pkg::SLOT_W-1:0]  m_task_id,
    input logic                        m_task_finished
);

    logic tick_acc;
    logic load_acc;

    assign tick_acc = s_valid && s_ready && (s_func == ets_pkg::FUNC_TICK);
    assign load_acc = s_valid && s_ready && (s_func == ets_pkg::FUNC_LOAD);

    // An idle tick carries no task
    `ETS_ASSERT_SAME(a_idle_clean, aclk, aresetn, m_valid && !m_task_ran, (m_task_id == '0) && !m_task_finished, "idle word carries task fields")

    // A tick word is scanned before the next input word is taken
    `ETS_ASSERT_NEXT(a_tick_busy, aclk, aresetn, tick_acc, !s_ready, "input ready right after a tick word")

    // A load word never produces a result word
    `ETS_ASSERT_NEXT(a_load_silent, aclk, aresetn, load_acc && !m_valid, !m_valid, "result word after a load word")

    // A stalled result word holds
    `ETS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_slot_time), "stalled result word changed")

endmodule

bind edf_task_scheduler ets_checker u_ets_checker (.*);

@@ dv/edf_sched_checker.sv @@
// Scoreboard for the EDF task scheduler: mirrors the task table and checks every result word
`timescale 1ns / 100ps

module edf_sched_checker #(
    parameter int MAX_TASKS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [ets_pkg::COUNT_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_func,
    input  logic [ets_pkg::SLOT_W-1:0]  s_task_slot,
    input  logic [ets_pkg::FIELD_W-1:0] s_release_time,
    input  logic [ets_pkg::FIELD_W-1:0] s_exec_time,
    input  logic [ets_pkg::FIELD_W-1:0] s_abs_deadline,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [ets_pkg::FIELD_W-1:0] m_slot_time,
    input  logic                        m_task_ran,
    input  logic [ets_pkg::SLOT_W-1:0]  m_task_id,
    input  logic                        m_task_finished,
    input  logic                        m_all_done,
    output int                          fail_count,
    output int                          outstanding
);
    import ets_pkg::*;

    // One expected result word per tick
    typedef struct packed {
        logic [FIELD_W-1:0] slot_time;
        logic               ran;
        logic [SLOT_W-1:0]  id;
        logic               finished;
        logic               all_done;
    } tick_report_t;

    // Mirror of the scheduler state
    logic [FIELD_W-1:0] rel_tab  [MAX_TASKS];
    logic [FIELD_W-1:0] rem_tab  [MAX_TASKS];
    logic [FIELD_W-1:0] dl_tab   [MAX_TASKS];
    logic               done_mark[MAX_TASKS];
    logic [FIELD_W-1:0] tick_now;
    logic [COUNT_W-1:0] done_total;
    logic [COUNT_W-1:0] task_count;

    tick_report_t expected_ticks[$];
    tick_report_t want;

    // Load word: a reload drops the entry's done mark, zero work is done at once
    function automatic void load_task(input logic [SLOT_W-1:0] slot,
                                      input logic [FIELD_W-1:0] rel,
                                      input logic [FIELD_W-1:0] ex,
                                      input logic [FIELD_W-1:0] dl);
        if (int'(slot) >= MAX_TASKS)
            return;
        if (done_mark[slot] && done_total != 0)
            done_total--;
        rel_tab[slot]   = rel;
        rem_tab[slot]   = ex;
        dl_tab[slot]    = dl;
        done_mark[slot] = 1'b0;
        if (ex == 0) begin
            done_mark[slot] = 1'b1;
            done_total++;
        end
    endfunction

    // Tick word: earliest deadline among released entries with work, lowest index on a tie
    function automatic tick_report_t run_edf_tick();
        int           scan_len;
        int           pick;
        logic         found;
        tick_report_t r;
        scan_len = (task_count < MAX_TASKS) ? int'(task_count) : MAX_TASKS;
        pick     = 0;
        found    = 1'b0;
        for (int i = 0; i < scan_len; i++) begin
            if (!done_mark[i] && rem_tab[i] != 0 && rel_tab[i] <= tick_now) begin
                if (!found || dl_tab[i] < dl_tab[pick]) begin
                    pick  = i;
                    found = 1'b1;
                end
            end
        end
        r.slot_time = tick_now;
        r.ran       = found;
        r.id        = found ? pick[SLOT_W-1:0] : '0;
        r.finished  = 1'b0;
        if (found) begin
            rem_tab[pick]--;
            if (rem_tab[pick] == 0) begin
                done_mark[pick] = 1'b1;
                done_total++;
                r.finished = 1'b1;
            end
        end
        r.all_done = (done_total == task_count);
        tick_now++;
        return r;
    endfunction

    function automatic void compare_field(input string name,
                                          input logic [FIELD_W-1:0] exp_val,
                                          input logic [FIELD_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Compare first: a word leaving at this edge belongs to an earlier tick
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_TASKS; i++)
                done_mark[i] = 1'b0;
            tick_now   = '0;
            done_total = '0;
            task_count = '0;
            expected_ticks.delete();
            fail_count = 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_ticks.size() == 0) begin
                    $error("result word with no tick outstanding: slot_time %0d", m_slot_time);
                    fail_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    compare_field("slot_time", want.slot_time, m_slot_time);
                    compare_field("task_ran", FIELD_W'(want.ran), FIELD_W'(m_task_ran));
                    compare_field("task_id", FIELD_W'(want.id), FIELD_W'(m_task_id));
                    compare_field("task_finished", FIELD_W'(want.finished),
                                  FIELD_W'(m_task_finished));
                    compare_field("all_done", FIELD_W'(want.all_done), FIELD_W'(m_all_done));
                end
            end
            if (cfg_we)
                task_count = cfg_wdata;
            if (s_valid && s_ready) begin
                if (s_func == FUNC_LOAD)
                    load_task(s_task_slot, s_release_time, s_exec_time, s_abs_deadline);
                else
                    expected_ticks.push_back(run_edf_tick());
            end
            outstanding <= expected_ticks.size();
        end
    end

endmodule

@@ dv/edf_task_scheduler_tb.sv @@
// Testbench top for the EDF task scheduler: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module edf_task_scheduler_tb;
    import ets_pkg::*;

    localparam int MAX_TASKS    = 16;
    localparam int DRAIN_CYCLES = 25;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_WORDS = 1600;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               cfg_we          = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata       = '0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic               s_func          = FUNC_LOAD;
    logic [SLOT_W-1:0]  s_task_slot     = '0;
    logic [FIELD_W-1:0] s_release_time  = '0;
    logic [FIELD_W-1:0] s_exec_time     = '0;
    logic [FIELD_W-1:0] s_abs_deadline  = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [FIELD_W-1:0] m_slot_time;
    logic               m_task_ran;
    logic [SLOT_W-1:0]  m_task_id;
    logic               m_task_finished;
    logic               m_all_done;

    int                 fail_count;
    int                 outstanding;
    int                 idle_pct     = 0;
    int                 stall_pct    = 0;
    bit                 hold_req     = 1'b0;
    logic [FIELD_W-1:0] tick_now     = '0;
    logic [COUNT_W-1:0] active_count = '0;
    int                 random_words = 0;

    always #5 aclk = ~aclk;

    edf_task_scheduler u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_task_slot     (s_task_slot),
        .s_release_time  (s_release_time),
        .s_exec_time     (s_exec_time),
        .s_abs_deadline  (s_abs_deadline),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot_time     (m_slot_time),
        .m_task_ran      (m_task_ran),
        .m_task_id       (m_task_id),
        .m_task_finished (m_task_finished),
        .m_all_done      (m_all_done)
    );

    edf_sched_checker #(.MAX_TASKS(MAX_TASKS)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_task_slot     (s_task_slot),
        .s_release_time  (s_release_time),
        .s_exec_time     (s_exec_time),
        .s_abs_deadline  (s_abs_deadline),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot_time     (m_slot_time),
        .m_task_ran      (m_task_ran),
        .m_task_id       (m_task_id),
        .m_task_finished (m_task_finished),
        .m_all_done      (m_all_done),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    // Result side: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Offer one word; valid stays up into the next word unless a gap is drawn
    task automatic send_word(input logic func, input logic [SLOT_W-1:0] slot,
                             input logic [FIELD_W-1:0] rel, ex, dl);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= func;
        s_task_slot    <= slot;
        s_release_time <= rel;
        s_exec_time    <= ex;
        s_abs_deadline <= dl;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (func == FUNC_TICK)
            tick_now++;
    endtask

    task automatic send_load(input int slot, input logic [FIELD_W-1:0] rel, ex, dl);
        send_word(FUNC_LOAD, slot[SLOT_W-1:0], rel, ex, dl);
    endtask

    // Tick words carry junk in the load fields
    task automatic send_tick();
        send_word(FUNC_TICK, SLOT_W'($urandom_range(0, 15)),
                  FIELD_W'($urandom_range(0, 16'hFFFF)),
                  FIELD_W'($urandom_range(0, 16'hFFFF)),
                  FIELD_W'($urandom_range(0, 16'hFFFF)));
    endtask

    // Hold the sender until every tick has reported and the block is quiet
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_task_count(input logic [COUNT_W-1:0] n);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        active_count  = n;
    endtask

    // Job fields: mostly short jobs released around now, with some outliers
    task automatic draw_job(output logic [FIELD_W-1:0] rel, ex, dl);
        rel = FIELD_W'(tick_now + $urandom_range(0, 8));
        ex  = FIELD_W'($urandom_range(1, 4));
        dl  = FIELD_W'(tick_now + $urandom_range(0, 60));
        case ($urandom_range(0, 9))
            0: begin
                rel = FIELD_W'($urandom_range(0, 16'hFFFF));
                ex  = FIELD_W'($urandom_range(0, 16'hFFFF));
                dl  = FIELD_W'($urandom_range(0, 16'hFFFF));
            end
            1: ex  = '0;
            2: rel = FIELD_W'($urandom_range(0, tick_now));
            3: dl  = tick_now + 16'd20;     // shared deadline, tie on index
            default: ;
        endcase
    endtask

    // Load entries in use, then tick them through with stray reloads mixed in
    task automatic run_job_set();
        int                 jobs;
        int                 ticks;
        int                 base;
        logic [FIELD_W-1:0] rel, ex, dl;
        jobs  = (active_count < MAX_TASKS) ? int'(active_count) : MAX_TASKS;
        base  = $urandom_range(0, 15);
        ticks = $urandom_range(jobs * 2 + 1, jobs * 3 + 6);
        if (ticks > 48)
            ticks = 48;
        for (int k = 0; k < jobs; k++) begin
            draw_job(rel, ex, dl);
            send_load((k + base) % jobs, rel, ex, dl);
            random_words++;
        end
        for (int t = 0; t < ticks; t++) begin
            if ($urandom_range(0, 9) == 0) begin
                draw_job(rel, ex, dl);
                send_load($urandom_range(0, 15), rel, ex, dl);
                random_words++;
            end
            send_tick();
            random_words++;
        end
    endtask

    initial begin
        int  scen;
        int  r;
        scen    = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: fill the whole table first so no scan meets an unwritten entry
        write_task_count('0);
        send_load(0, 16'd0, 16'd0, 16'd5);              // zero work: done on load
        send_load(1, 16'd0, 16'd2, 16'd100);
        send_load(2, 16'd0, 16'd1, 16'd100);            // same deadline as entry 1
        send_load(3, 16'd2, 16'd1, 16'd10);             // arrives later and preempts
        for (int k = 4; k < 14; k++)
            send_load(k, FIELD_W'(k) | 16'h8000, (k % 2) ? 16'hAAAA : 16'h5555,
                      16'hFFFF - FIELD_W'(k));
        send_load(14, 16'd0, 16'd1, 16'd0);
        send_load(15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick();                                    // nothing scanned
        write_task_count(COUNT_W'(MAX_TASKS));
        repeat (5) send_tick();
        send_load(0, 16'd0, 16'd1, 16'd0);              // reload of a finished entry
        send_tick();
        write_task_count(COUNT_W'(31));                 // beyond the table
        send_tick();

        // Random job sets across idling phases
        while (random_words < RANDOM_WORDS) begin
            scen++;
            case ((scen / 4) % 5)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 84; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 84; end
                3: begin idle_pct = 21; stall_pct = 21; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase

            if (scen % 6 == 1) begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    write_task_count('0);
                else if (r == 1)
                    write_task_count(COUNT_W'(MAX_TASKS));
                else if (r == 2)
                    write_task_count(COUNT_W'($urandom_range(17, 31)));
                else
                    write_task_count(COUNT_W'($urandom_range(1, 8)));
            end

            // Back-pressure: result side held off while ticks keep coming
            if (scen % 37 == 10) begin
                idle_pct = 0;
                hold_req = 1'b1;
                repeat (30) begin
                    send_tick();
                    random_words++;
                end
            end

            run_job_set();
        end

        wait_drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
